// ===== hdl/dsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsg_pkg: shared types and constants of the depth sentence generator
// Command and status structs between controller and datapath, byte select
// codes and the character helpers used to build the sentences.
// ----------------------------------------------------------------------------
package dsg_pkg;

  typedef logic [7:0] byte_t;

  // Width of a depth field and of a value's magnitude.
  localparam int MAG_W     = 18;
  // BCD digits needed for the largest magnitude (262143).
  localparam int BCD_N     = 6;
  localparam int DIG_IDX_W = 3;
  localparam int CNT_W     = 5;
  localparam int IN_DATA_W = 40;

  localparam int HEAD_LEN     = 10;
  localparam int HEAD_LEN_DPT = 7;
  localparam int TAIL_LEN     = 6;
  localparam int END_LEN      = 4;

  localparam logic [1:0] KIND_DBT = 2'd0;
  localparam logic [1:0] KIND_DBS = 2'd1;
  localparam logic [1:0] KIND_DBK = 2'd2;
  localparam logic [1:0] KIND_DPT = 2'd3;

  typedef logic [2:0] bsel_t;
  localparam bsel_t BS_HEAD  = 3'd0;
  localparam bsel_t BS_TAIL  = 3'd1;
  localparam bsel_t BS_COMMA = 3'd2;
  localparam bsel_t BS_STAR  = 3'd3;
  localparam bsel_t BS_MINUS = 3'd4;
  localparam bsel_t BS_DIGIT = 3'd5;
  localparam bsel_t BS_DOT   = 3'd6;
  localparam bsel_t BS_END   = 3'd7;

  typedef struct packed {
    logic             load;
    logic             conv_start;
    logic             conv_second;
    logic             conv_step;
    logic             push;
    bsel_t            sel;
    logic [CNT_W-1:0] idx;
    logic             last;
  } dsg_cmd_t;

  typedef struct packed {
    logic                 enabled;
    logic                 is_dpt;
    logic                 sign;
    logic [DIG_IDX_W-1:0] top;
    logic                 can_push;
  } dsg_stat_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // "$SDDBT,,f,", "$SDDBS,,f,", "$SDDBK,,f," and "$SDDPT,".
  function automatic byte_t head_char(input logic [1:0] kind, input logic [3:0] idx);
    byte_t c;
    case (idx)
      4'd0: c = "$";
      4'd1: c = "S";
      4'd2: c = "D";
      4'd3: c = "D";
      4'd4: c = (kind == KIND_DPT) ? "P" : "B";
      4'd5: begin
        case (kind)
          KIND_DBT: c = "T";
          KIND_DBS: c = "S";
          KIND_DBK: c = "K";
          default:  c = "T";
        endcase
      end
      4'd8:    c = "f";
      default: c = ",";
    endcase
    return c;
  endfunction

  // ",M,,F*"
  function automatic byte_t tail_char(input logic [2:0] idx);
    byte_t c;
    case (idx)
      3'd1:    c = "M";
      3'd4:    c = "F";
      3'd5:    c = "*";
      default: c = ",";
    endcase
    return c;
  endfunction

  function automatic byte_t hex_char(input logic [3:0] d);
    byte_t c;
    c = (d > 4'd9) ? (8'd55 + {4'd0, d}) : (8'd48 + {4'd0, d});
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/dsg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsg_dp: datapath of the depth sentence generator
// Request and enable registers, saturation, shift-and-add-3 binary to BCD
// converter, byte selection, running checksum and the output register.
// ----------------------------------------------------------------------------
module dsg_dp
  import dsg_pkg::*;
#(
  parameter int INT_DIGITS = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [IN_DATA_W-1:0]  in_tdata,
  input  wire [1:0]            in_tuser,
  input  wire                  cfg_wr_en,
  input  wire [3:0]            cfg_wr_data,
  input  dsg_cmd_t             cmd,
  output dsg_stat_t            stat,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  localparam logic [63:0] SAT_LIMIT = pow10(INT_DIGITS + 1) - 64'd1;

  logic [3:0]                en_r;
  logic [1:0]                kind_r;
  logic signed [MAG_W-1:0]   prim_r;
  logic signed [MAG_W-1:0]   surf_r;
  logic [MAG_W-1:0]          bin_r;
  logic [BCD_N-1:0][3:0]     bcd_r;
  logic                      sign_r;
  byte_t                     chk_r;
  logic                      chk_done_r;
  logic                      out_valid_r;
  byte_t                     out_data_r;
  logic                      out_last_r;

  logic signed [MAG_W:0]     val;
  logic                      neg;
  logic [MAG_W:0]            mag_full;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W-1:0]          mag_sat;
  logic [BCD_N-1:0][3:0]     bcd_adj;
  logic [BCD_N*4-1:0]        bcd_adj_flat;
  logic [DIG_IDX_W-1:0]      top;
  byte_t                     byte_sel;

  // Value to convert: the primary depth, or surface minus primary for DPT.
  always_comb begin
    if (cmd.conv_second) begin
      val = {surf_r[MAG_W-1], surf_r} - {prim_r[MAG_W-1], prim_r};
    end else begin
      val = {prim_r[MAG_W-1], prim_r};
    end
    neg      = val[MAG_W];
    mag_full = neg ? (~val + 1'b1) : val;
    mag      = mag_full[MAG_W-1:0];
    mag_sat  = (64'(mag) > SAT_LIMIT) ? SAT_LIMIT[MAG_W-1:0] : mag;
  end

  always_comb begin
    for (int i = 0; i < BCD_N; i++) begin
      bcd_adj[i] = (bcd_r[i] > 4'd4) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
    bcd_adj_flat = bcd_adj;
  end

  // Highest nonzero integer digit; the units digit always shows.
  always_comb begin
    top = DIG_IDX_W'(1);
    for (int i = 2; i < BCD_N; i++) begin
      if (bcd_r[i] != 4'd0) begin
        top = DIG_IDX_W'(i);
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      BS_HEAD:  byte_sel = head_char(kind_r, cmd.idx[3:0]);
      BS_TAIL:  byte_sel = tail_char(cmd.idx[2:0]);
      BS_COMMA: byte_sel = ",";
      BS_STAR:  byte_sel = "*";
      BS_MINUS: byte_sel = "-";
      BS_DIGIT: byte_sel = "0" + {4'd0, bcd_r[cmd.idx[DIG_IDX_W-1:0]]};
      BS_DOT:   byte_sel = ".";
      BS_END: begin
        case (cmd.idx[1:0])
          2'd0:    byte_sel = hex_char(chk_r[7:4]);
          2'd1:    byte_sel = hex_char(chk_r[3:0]);
          2'd2:    byte_sel = 8'h0D;
          default: byte_sel = 8'h0A;
        endcase
      end
      default:  byte_sel = ",";
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 4'd0;
      out_valid_r <= 1'b0;
      chk_done_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        chk_done_r <= 1'b0;
      end else if (cmd.push && byte_sel == "*") begin
        chk_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_tuser;
      prim_r <= in_tdata[MAG_W-1:0];
      surf_r <= in_tdata[2*MAG_W-1:MAG_W];
      chk_r  <= 8'd0;
    end else if (cmd.push && !chk_done_r && byte_sel != "*" && byte_sel != "$") begin
      chk_r <= chk_r ^ byte_sel;
    end
    if (cmd.conv_start) begin
      bin_r  <= mag_sat;
      bcd_r  <= '0;
      sign_r <= neg;
    end else if (cmd.conv_step) begin
      bcd_r <= {bcd_adj_flat[BCD_N*4-2:0], bin_r[MAG_W-1]};
      bin_r <= {bin_r[MAG_W-2:0], 1'b0};
    end
    if (cmd.push) begin
      out_data_r <= byte_sel;
      out_last_r <= cmd.last;
    end
  end

  assign stat.enabled  = en_r[kind_r];
  assign stat.is_dpt   = (kind_r == KIND_DPT);
  assign stat.sign     = sign_r;
  assign stat.top      = top;
  assign stat.can_push = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/dsg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsg_ctrl: sequencer of the depth sentence generator
// Walks through the parts of a sentence, starts the conversions and tells
// the datapath which byte to load into the output register.
// ----------------------------------------------------------------------------
module dsg_ctrl
  import dsg_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  dsg_stat_t  stat,
  output dsg_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CONV  = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_SIGN  = 4'd4;
  localparam logic [3:0] S_INT   = 4'd5;
  localparam logic [3:0] S_DOT   = 4'd6;
  localparam logic [3:0] S_FRAC  = 4'd7;
  localparam logic [3:0] S_COMMA = 4'd8;
  localparam logic [3:0] S_STAR  = 4'd9;
  localparam logic [3:0] S_TAIL  = 4'd10;
  localparam logic [3:0] S_END   = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             second_r, second_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    second_nxt = second_r;
    cmd        = '0;
    cmd.sel    = BS_COMMA;
    cmd.idx    = cnt_r;
    in_tready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.enabled) begin
          cmd.conv_start = 1'b1;
          second_nxt     = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_CONV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = second_r ? S_SIGN : S_HEAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_HEAD: begin
        cmd.sel = BS_HEAD;
        if (stat.can_push) begin
          cmd.push = 1'b1;
          if (cnt_r == CNT_W'(stat.is_dpt ? HEAD_LEN_DPT - 1 : HEAD_LEN - 1)) begin
            state_nxt = S_SIGN;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_SIGN: begin
        // A positive value or zero skips the minus sign.
        cmd.sel = BS_MINUS;
        if (!stat.sign || stat.can_push) begin
          cmd.push  = stat.sign;
          cnt_nxt   = CNT_W'(stat.top);
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        cmd.sel = BS_DIGIT;
        if (stat.can_push) begin
          cmd.push = 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_DOT;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      S_DOT: begin
        cmd.sel = BS_DOT;
        if (stat.can_push) begin
          cmd.push  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_FRAC;
        end
      end
      S_FRAC: begin
        cmd.sel = BS_DIGIT;
        if (stat.can_push) begin
          cmd.push = 1'b1;
          cnt_nxt  = '0;
          if (second_r) begin
            state_nxt = S_STAR;
          end else if (stat.is_dpt) begin
            state_nxt = S_COMMA;
          end else begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_COMMA: begin
        cmd.sel = BS_COMMA;
        if (stat.can_push) begin
          cmd.push        = 1'b1;
          cmd.conv_start  = 1'b1;
          cmd.conv_second = 1'b1;
          second_nxt      = 1'b1;
          cnt_nxt         = '0;
          state_nxt       = S_CONV;
        end
      end
      S_STAR: begin
        cmd.sel = BS_STAR;
        if (stat.can_push) begin
          cmd.push  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_END;
        end
      end
      S_TAIL: begin
        cmd.sel = BS_TAIL;
        if (stat.can_push) begin
          cmd.push = 1'b1;
          if (cnt_r == CNT_W'(TAIL_LEN - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_END;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_END: begin
        cmd.sel = BS_END;
        if (stat.can_push) begin
          cmd.push = 1'b1;
          if (cnt_r == CNT_W'(END_LEN - 1)) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      second_r <= second_nxt;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> stat.can_push)
    else $error("byte loaded while the output register is still full");

  a_digit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INT) |-> (cnt_r != '0 && cnt_r < CNT_W'(BCD_N)))
    else $error("integer digit index out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && cmd.last) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after the line feed");

  a_second_dpt: assert property (@(posedge clk) disable iff (!rst_n)
    (second_r && state_r != S_IDLE && state_r != S_CHECK) |-> stat.is_dpt)
    else $error("second value converted for a sentence other than DPT");

endmodule
`default_nettype wire

// ===== hdl/depth_sentence_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depth_sentence_generator_unit: depth sentence encoder, top level
// Turns one depth request into an ASCII DBT, DBS, DBK or DPT sentence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per transfer. in_tuser holds the
//   sentence kind, in_tdata the primary and surface depths in tenths of a
//   metre. in_tready is high only while no sentence is in progress.
//   Output channel (out_*): the sentence one byte per transfer; out_tlast
//   marks the closing line feed. A kind whose bit in the enable register is
//   clear produces no bytes.
//   Configuration (cfg_*): a write of the 4-bit enable register. The user
//   must write it only while the block is idle; the block does not enforce this.
// Sequence: each value goes through a shift-and-add-3 binary to BCD
//   conversion before its digits are sent; a DPT sentence converts its
//   second value after the comma. A new request is taken only once the
//   sequencer has handed the last byte of a sentence to the output
//   register, or has dropped a suppressed request.
// Back pressure: a single output register holds the current byte; while the
//   receiver stalls, the sequencer waits and nothing is lost.
// Reset: clears the enable register (all kinds suppressed), the sequencer
//   and the output valid flag.
// ----------------------------------------------------------------------------
module depth_sentence_generator_unit
  import dsg_pkg::*;
#(
  parameter int INT_DIGITS = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire [IN_DATA_W-1:0]  in_tdata,   // [17:0] primary_depth, [35:18] surface_depth
  input  wire [1:0]            in_tuser,   // [1:0] req_type
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic                 out_tlast,
  input  wire                  cfg_wr_en,
  input  wire [3:0]            cfg_wr_data
);

  dsg_cmd_t  cmd;
  dsg_stat_t stat;

  dsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dsg_dp #(
    .INT_DIGITS (INT_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_depth_sentence_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_depth_sentence_generator_unit: self-checking bench for the depth encoder
// Sends depth requests of every kind under several enable masks. It builds
// each expected sentence byte by byte, checksum and line end included, and
// compares every byte leaving the block and its last flag with that list.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_depth_sentence_generator_unit;
  import dsg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS       = 4;
  localparam longint DEPTH_MAX = 64'(pow10(DIGITS + 1)) - 1;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_IDLE     = 17;
  localparam int RANDOM_ITEMS = 410;

  localparam byte_t CHAR_CR = 8'h0D;
  localparam byte_t CHAR_LF = 8'h0A;

  typedef struct packed {
    byte_t ch;
    logic  last;
  } sentence_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  wire                  in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0]           in_tuser = '0;
  wire                  out_tvalid;
  logic                 out_tready = 1'b0;
  wire  [7:0]           out_tdata;
  wire                  out_tlast;
  logic                 cfg_wr_en = 1'b0;
  logic [3:0]           cfg_wr_data = '0;

  sentence_byte_t pending_bytes[$];
  byte_t          text_buf[$];
  sentence_byte_t head_byte;
  logic [3:0]     enable_model = '0;
  int             mismatches = 0;
  int             cycle_count = 0;
  int             rx_hold = 0;
  int             rx_draw = 0;
  bit             tx_no_gaps = 1'b0;
  bit             rx_no_stalls = 1'b0;

  depth_sentence_generator_unit #(
    .INT_DIGITS(DIGITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("depth_sentence_generator_unit: mismatch");
      $finish;
    end
  end

  function automatic void note_mismatch(input string msg);
    if (mismatches < 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatches++;
  endfunction

  // Appends a depth as [-]digits.d, saturated to the integer digits available.
  function automatic void append_depth(input longint v);
    longint mag;
    longint ip;
    byte_t  digs[$];
    mag = (v < 0) ? -v : v;
    if (mag > DEPTH_MAX) begin
      mag = DEPTH_MAX;
    end
    if (v < 0 && mag != 0) begin
      text_buf.push_back("-");
    end
    ip = mag / 10;
    do begin
      digs.push_front(byte_t'("0" + ip % 10));
      ip = ip / 10;
    end while (ip != 0);
    foreach (digs[i]) begin
      text_buf.push_back(digs[i]);
    end
    text_buf.push_back(".");
    text_buf.push_back(byte_t'("0" + mag % 10));
  endfunction

  function automatic byte_t hex_ascii(input logic [3:0] nib);
    return (nib > 4'd9) ? byte_t'("A" + nib - 10) : byte_t'("0" + nib);
  endfunction

  // Queues the bytes of the sentence that one accepted request should produce.
  function automatic void predict_sentence(input logic [1:0] kind,
                                           input logic signed [17:0] prim,
                                           input logic signed [17:0] surf);
    string head;
    byte_t sum;
    int    i;
    if (!enable_model[kind]) begin
      return;
    end
    text_buf.delete();
    case (kind)
      KIND_DBT: head = "$SDDBT,,f,";
      KIND_DBS: head = "$SDDBS,,f,";
      KIND_DBK: head = "$SDDBK,,f,";
      default:  head = "$SDDPT,";
    endcase
    for (i = 0; i < head.len(); i++) begin
      text_buf.push_back(head[i]);
    end
    append_depth(longint'(prim));
    if (kind == KIND_DPT) begin
      // The second DPT field is the offset from transducer to surface.
      text_buf.push_back(",");
      append_depth(longint'(surf) - longint'(prim));
      text_buf.push_back("*");
    end else begin
      head = ",M,,F*";
      for (i = 0; i < head.len(); i++) begin
        text_buf.push_back(head[i]);
      end
    end
    sum = '0;
    for (i = 1; i < text_buf.size() && text_buf[i] != "*"; i++) begin
      sum ^= text_buf[i];
    end
    text_buf.push_back(hex_ascii(sum[7:4]));
    text_buf.push_back(hex_ascii(sum[3:0]));
    text_buf.push_back(CHAR_CR);
    text_buf.push_back(CHAR_LF);
    foreach (text_buf[k]) begin
      pending_bytes.push_back('{ch: text_buf[k], last: (k == text_buf.size() - 1)});
    end
  endfunction

  // Receiver: a fresh stall length is drawn after every byte taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      rx_draw = rx_no_stalls ? 0 : $urandom_range(0, MAX_IDLE);
      rx_hold <= rx_draw;
      out_tready <= (rx_draw == 0);
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch($sformatf("byte %h (last %b) with none expected", out_tdata, out_tlast));
      end else begin
        head_byte = pending_bytes.pop_front();
        if (out_tdata !== head_byte.ch || out_tlast !== head_byte.last) begin
          note_mismatch($sformatf("expected byte %h last %b, got byte %h last %b",
                                  head_byte.ch, head_byte.last, out_tdata, out_tlast));
        end
      end
    end
  end

  // Valid stays high between back-to-back requests; it drops only for a gap or while the bench waits for idle.
  task automatic send_request(input logic [1:0] kind, input logic signed [17:0] prim,
                              input logic signed [17:0] surf);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, surf, prim};
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    predict_sentence(kind, prim, surf);
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    // A suppressed request may still be in the sequencer.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable_mask(input logic [3:0] mask);
    wait_until_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    enable_model = mask;
  endtask

  function automatic logic signed [17:0] random_depth();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      v = int'($urandom_range(0, 2000)) - 1000;
    end else if (pick < 6) begin
      v = int'($urandom_range(0, 199998)) - 99999;
    end else if (pick < 8) begin
      v = 99990 + int'($urandom_range(0, 20));
      if ($urandom_range(0, 1) == 1) begin
        v = -v;
      end
    end else begin
      v = int'($urandom_range(0, 262143)) - 131072;
    end
    return v[17:0];
  endfunction

  // After reset every kind is suppressed.
  task automatic test_disabled_after_reset();
    send_request(KIND_DBT, 18'sd25, 18'sd0);
    send_request(KIND_DBS, 18'sd25, 18'sd0);
    send_request(KIND_DBK, 18'sd25, 18'sd0);
    send_request(KIND_DPT, 18'sd25, 18'sd40);
  endtask

  task automatic test_value_formats();
    write_enable_mask(4'hF);
    send_request(KIND_DBT, 18'sd0, 18'sd0);
    send_request(KIND_DBS, -18'sd5, 18'sd0);
    send_request(KIND_DBK, 18'sd5, 18'sd0);
    send_request(KIND_DBT, 18'sd10, 18'sd0);
    send_request(KIND_DBK, -18'sd1, 18'sd0);
    send_request(KIND_DBT, 18'sd99999, 18'sd0);
    send_request(KIND_DBS, -18'sd99999, 18'sd0);
    send_request(KIND_DBK, 18'sd100000, -18'sd1);
    send_request(KIND_DBT, -18'sd131072, -18'sd131072);
    send_request(KIND_DBS, 18'sd131071, 18'sd131071);
    send_request(KIND_DPT, 18'sd123, 18'sd456);
    send_request(KIND_DPT, 18'sd7, 18'sd7);
    send_request(KIND_DPT, 18'sd0, 18'sd0);
    // Offsets beyond the digit range saturate in both directions.
    send_request(KIND_DPT, 18'sd99999, -18'sd99999);
    send_request(KIND_DPT, -18'sd99999, 18'sd99999);
    send_request(KIND_DPT, -18'sd131072, 18'sd131071);
  endtask

  task automatic test_random_requests();
    logic [3:0] mask;
    logic [1:0] kind;
    int phase;
    int counted;
    int sent;
    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      case (phase)
        0:       mask = 4'hF;
        1:       mask = 4'h0;
        2:       mask = 4'h1;
        3:       mask = 4'h2;
        4:       mask = 4'h4;
        5:       mask = 4'h8;
        6:       mask = 4'hF;
        default: mask = 4'($urandom_range(1, 15));
      endcase
      write_enable_mask(mask);
      sent = 0;
      while (sent < ((mask == 4'h0) ? 8 : 40) && counted < RANDOM_ITEMS) begin
        if (sent % 20 == 0) begin
          tx_no_gaps = ($urandom_range(0, 3) == 0);
          rx_no_stalls = ($urandom_range(0, 3) == 0);
        end
        kind = 2'($urandom_range(0, 3));
        if (mask != 4'h0 && $urandom_range(0, 9) < 7) begin
          while (!mask[kind]) kind = 2'($urandom_range(0, 3));
        end
        send_request(kind, random_depth(), random_depth());
        sent++;
        counted++;
      end
      phase++;
    end
    tx_no_gaps = 1'b0;
    rx_no_stalls = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_after_reset();
    test_value_formats();
    test_random_requests();
    wait_until_idle();
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("depth_sentence_generator_unit: match");
    end else begin
      $display("depth_sentence_generator_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dsg_pkg.sv
hdl/dsg_dp.sv
hdl/dsg_ctrl.sv
hdl/depth_sentence_generator_unit.sv
tb/sv/tb_depth_sentence_generator_unit.sv
